// ===== src/ptmr_pkg.sv =====
// ptmr_pkg: shared codes, field positions and helpers for the protection table refill block
// no dependencies; imported by the slot store, the top level and the checker
package ptmr_pkg;

    // input operation codes
    localparam logic [1:0] OP_LOAD_DESC = 2'd0;
    localparam logic [1:0] OP_LOAD_SLOT = 2'd1;
    localparam logic [1:0] OP_MISS      = 2'd2;

    // result status codes
    localparam logic [1:0] STATUS_DONE    = 2'd0;
    localparam logic [1:0] STATUS_DEFER   = 2'd1;
    localparam logic [1:0] STATUS_NO_DESC = 2'd2;
    localparam logic [1:0] STATUS_LOCKED  = 2'd3;

    // layout of a 64-bit entry: start in the low word, attributes in the high word
    localparam int ATTR_LSB = 32;
    localparam int SIZE_LSB = ATTR_LSB + 16;
    localparam int LOCK_POS = ATTR_LSB + 1;

    // page sizes, one bit wider than an address so that the end never wraps
    localparam logic [32:0] PAGE_1K = 33'd1024;
    localparam logic [32:0] PAGE_4K = 33'd4096;
    localparam logic [32:0] PAGE_1M = 33'd1048576;
    localparam logic [32:0] PAGE_4M = 33'd4194304;

    typedef logic [63:0] ptmr_entry_t;

    // slot store access strobes
    typedef struct packed {
        logic rd;
        logic wr;
    } ptmr_slot_ctl_t;

    function automatic logic [32:0] page_size(input logic [1:0] code);
        logic [32:0] size;
        case (code)
            2'd0:    size = PAGE_1K;
            2'd1:    size = PAGE_4K;
            2'd2:    size = PAGE_1M;
            default: size = PAGE_4M;
        endcase
        return size;
    endfunction

endpackage

// ===== src/ptmr_ifs.sv =====
// ptmr channel interfaces: request, response and configuration write channels
// depends on ptmr_pkg for nothing but keeps the same field widths as its users

interface ptmr_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic        side;
    logic [7:0]  entry_index;
    logic [31:0] start_word;
    logic [31:0] attr_word;
    logic [31:0] fault_addr;
    logic [31:0] return_addr;

    modport source (output valid, op, side, entry_index, start_word, attr_word,
                    fault_addr, return_addr, input ready);
    modport sink (input valid, op, side, entry_index, start_word, attr_word,
                  fault_addr, return_addr, output ready);
endinterface

interface ptmr_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [7:0] found_index;
    logic [5:0] removed_slot;

    modport source (output valid, status, found_index, removed_slot, input ready);
    modport sink (input valid, status, found_index, removed_slot, output ready);
endinterface

interface ptmr_cfg_if;
    logic valid;
    logic ready;
    logic data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// ===== src/ptmr_slot_store.sv =====
// ptmr_slot_store: protection slot memory for both sides with per-entry valid bits
// depends on ptmr_pkg; an entry never written since reset reads as zero
module ptmr_slot_store
    import ptmr_pkg::*;
#(
    parameter int AW = 5
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  ptmr_slot_ctl_t ctl,
    input  logic [AW-1:0]  rd_addr,
    input  logic [AW-1:0]  wr_addr,
    input  ptmr_entry_t    wr_data,
    output ptmr_entry_t    rd_data
);

    localparam int DEPTH = 2 ** AW;

    ptmr_entry_t           mem [DEPTH];
    logic [DEPTH-1:0]      valid_reg;
    logic [DEPTH-1:0]      valid_next;
    ptmr_entry_t           rd_word_reg;
    logic                  rd_valid_reg;

    // memory write and registered read
    always_ff @(posedge clk)
    begin
        if (ctl.wr)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd)
        begin
            rd_word_reg <= mem[rd_addr];
        end
    end

    // valid bits set on write
    always_comb
    begin
        valid_next = valid_reg;
        if (ctl.wr)
        begin
            valid_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (ctl.rd)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // unwritten entries read as the reset value
    assign rd_data = rd_valid_reg ? rd_word_reg : '0;

endmodule

// ===== src/protection_table_miss_refill.sv =====
// protection_table_miss_refill: descriptor tables, refill sequencer and result register
// depends on ptmr_pkg, the ptmr channel interfaces and ptmr_slot_store
//
// Usage: req carries one beat per item: a descriptor load, a protection slot load
// or a miss event, each for the instruction or the data side. rsp returns exactly
// one beat per item (status, covering descriptor index, removed slot). cfg writes
// the repeat-fault workaround bit at any beat; write it only while the block idles.
// Flow: a load or a deferred miss is held as the pending result in the sequencer, then
// moves into the result register that drives rsp. A miss scans the descriptor table
// entry by entry (read, then compare), then walks the slots (lock search, then shift
// down). Its pace is set by the single read port of the descriptor memory and of the
// slot memory, each with registered read data, under one sequencer.
// One item is in work at a time: req.ready is high only while the sequencer idles.
// The result register lets the next item in while the previous result waits on a
// stalled rsp; a finished result then waits in the sequencer until rsp frees up.
// Reset: slots read as zero through their valid bits (no clearing pass), the last
// return address clears, the workaround bit sets; descriptors are undefined.
module protection_table_miss_refill
    import ptmr_pkg::*;
#(
    parameter int TABLE_DEPTH = 32,
    parameter int SLOT_COUNT  = 16
)
(
    input  logic            clk,
    input  logic            rst_n,
    ptmr_req_if.sink        req,
    ptmr_rsp_if.source      rsp,
    ptmr_cfg_if.sink        cfg
);

    localparam int TIW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int SIW = $clog2(SLOT_COUNT);
    localparam int TAW = TIW + 1;
    localparam int SAW = SIW + 1;
    localparam int DESC_DEPTH = 2 ** TAW;
    localparam logic [TIW-1:0] LAST_DESC = TIW'(TABLE_DEPTH - 1);
    localparam logic [SIW-1:0] LAST_SLOT = SIW'(SLOT_COUNT - 1);

    // sequencer states
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_SCAN_RD  = 4'd1;
    localparam logic [3:0] S_SCAN_CMP = 4'd2;
    localparam logic [3:0] S_LOCK_RD  = 4'd3;
    localparam logic [3:0] S_LOCK_CHK = 4'd4;
    localparam logic [3:0] S_SHIFT_RD = 4'd5;
    localparam logic [3:0] S_SHIFT_WR = 4'd6;
    localparam logic [3:0] S_FILL     = 4'd7;
    localparam logic [3:0] S_RESP     = 4'd8;

    logic [3:0]     state_reg, state_next;
    logic           side_reg, side_next;
    logic [31:0]    addr_reg, addr_next;
    logic [TIW-1:0] i_reg, i_next;
    logic [SIW-1:0] j_reg, j_next;
    ptmr_entry_t    found_word_reg, found_word_next;
    logic [1:0]     res_status_reg, res_status_next;
    logic [7:0]     res_found_reg, res_found_next;
    logic [5:0]     res_removed_reg, res_removed_next;
    logic           out_valid_reg, out_valid_next;
    logic [1:0]     out_status_reg;
    logic [7:0]     out_found_reg;
    logic [5:0]     out_removed_reg;
    logic [31:0]    last_ret_reg, last_ret_next;
    logic           workaround_reg, workaround_next;
    ptmr_entry_t    desc_rd_reg;

    ptmr_entry_t    desc_mem [DESC_DEPTH];
    logic           desc_we;
    logic           desc_re;
    logic [TAW-1:0] desc_waddr;
    logic [TAW-1:0] desc_raddr;
    ptmr_entry_t    load_word;

    ptmr_slot_ctl_t slot_ctl;
    logic [SAW-1:0] slot_raddr;
    logic [SAW-1:0] slot_waddr;
    ptmr_entry_t    slot_wdata;
    ptmr_entry_t    slot_rdata;

    logic [32:0]    range_start;
    logic [32:0]    range_end;
    logic [32:0]    range_addr;
    logic           covers;
    logic           out_load;
    logic           desc_in_range;
    logic           slot_in_range;

    assign load_word = {req.attr_word, req.start_word};
    assign desc_in_range = {1'b0, req.entry_index} < 9'(TABLE_DEPTH);
    assign slot_in_range = {1'b0, req.entry_index} < 9'(SLOT_COUNT);

    // range test on the descriptor just read, one bit wider than an address so the end never wraps
    assign range_start = {1'b0, desc_rd_reg[31:0]};
    assign range_end   = range_start + page_size(desc_rd_reg[SIZE_LSB+1:SIZE_LSB]);
    assign range_addr  = {1'b0, addr_reg};
    assign covers      = (range_start <= range_addr) && (range_end > range_addr);

    // result register takes the pending result when free or when its beat is taken
    assign out_load = (state_reg == S_RESP) && (!out_valid_reg || rsp.ready);

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        side_next        = side_reg;
        addr_next        = addr_reg;
        i_next           = i_reg;
        j_next           = j_reg;
        found_word_next  = found_word_reg;
        res_status_next  = res_status_reg;
        res_found_next   = res_found_reg;
        res_removed_next = res_removed_reg;
        last_ret_next    = last_ret_reg;
        desc_we          = 1'b0;
        desc_re          = 1'b0;
        desc_waddr       = {req.side, req.entry_index[TIW-1:0]};
        desc_raddr       = {side_reg, i_reg};
        slot_ctl         = '0;
        slot_raddr       = {side_reg, j_reg};
        slot_waddr       = {side_reg, j_reg};
        slot_wdata       = slot_rdata;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    side_next        = req.side;
                    addr_next        = req.fault_addr;
                    i_next           = '0;
                    j_next           = '0;
                    res_status_next  = STATUS_DONE;
                    res_found_next   = '0;
                    res_removed_next = '0;
                    state_next       = S_RESP;
                    unique case (req.op)
                        OP_LOAD_DESC:
                        begin
                            desc_we = desc_in_range;
                        end
                        OP_LOAD_SLOT:
                        begin
                            slot_ctl.wr = slot_in_range;
                            slot_waddr  = {req.side, req.entry_index[SIW-1:0]};
                            slot_wdata  = load_word;
                        end
                        OP_MISS:
                        begin
                            state_next = S_SCAN_RD;
                            if (req.side && workaround_reg)
                            begin
                                last_ret_next = req.return_addr;
                                if (last_ret_reg != req.return_addr)
                                begin
                                    res_status_next = STATUS_DEFER;
                                    state_next      = S_RESP;
                                end
                            end
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end
            S_SCAN_RD:
            begin
                desc_re    = 1'b1;
                state_next = S_SCAN_CMP;
            end
            S_SCAN_CMP:
            begin
                if (covers)
                begin
                    found_word_next = desc_rd_reg;
                    res_found_next  = 8'(i_reg);
                    state_next      = S_LOCK_RD;
                end
                else if (i_reg == LAST_DESC)
                begin
                    res_status_next = STATUS_NO_DESC;
                    state_next      = S_RESP;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_SCAN_RD;
                end
            end
            S_LOCK_RD:
            begin
                slot_ctl.rd = 1'b1;
                state_next  = S_LOCK_CHK;
            end
            S_LOCK_CHK:
            begin
                if (!slot_rdata[LOCK_POS])
                begin
                    res_removed_next = 6'(j_reg);
                    state_next       = (j_reg == LAST_SLOT) ? S_FILL : S_SHIFT_RD;
                end
                else if (j_reg == LAST_SLOT)
                begin
                    res_status_next = STATUS_LOCKED;
                    state_next      = S_RESP;
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = S_LOCK_RD;
                end
            end
            S_SHIFT_RD:
            begin
                slot_ctl.rd = 1'b1;
                slot_raddr  = {side_reg, j_reg + 1'b1};
                state_next  = S_SHIFT_WR;
            end
            S_SHIFT_WR:
            begin
                slot_ctl.wr = 1'b1;
                j_next      = j_reg + 1'b1;
                state_next  = ((j_reg + 1'b1) == LAST_SLOT) ? S_FILL : S_SHIFT_RD;
            end
            S_FILL:
            begin
                slot_ctl.wr     = 1'b1;
                slot_waddr      = {side_reg, LAST_SLOT};
                slot_wdata      = found_word_reg;
                res_status_next = STATUS_DONE;
                state_next      = S_RESP;
            end
            S_RESP:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output valid and configuration bit
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        workaround_next = cfg.valid ? cfg.data : workaround_reg;
    end

    // descriptor memory, both sides, registered read
    always_ff @(posedge clk)
    begin
        if (desc_we)
        begin
            desc_mem[desc_waddr] <= load_word;
        end
        if (desc_re)
        begin
            desc_rd_reg <= desc_mem[desc_raddr];
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            last_ret_reg   <= '0;
            workaround_reg <= 1'b1;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            last_ret_reg   <= last_ret_next;
            workaround_reg <= workaround_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        side_reg        <= side_next;
        addr_reg        <= addr_next;
        i_reg           <= i_next;
        j_reg           <= j_next;
        found_word_reg  <= found_word_next;
        res_status_reg  <= res_status_next;
        res_found_reg   <= res_found_next;
        res_removed_reg <= res_removed_next;
        if (out_load)
        begin
            out_status_reg  <= res_status_reg;
            out_found_reg   <= res_found_reg;
            out_removed_reg <= res_removed_reg;
        end
    end

    ptmr_slot_store #(
        .AW (SAW)
    ) u_slots (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (slot_ctl),
        .rd_addr (slot_raddr),
        .wr_addr (slot_waddr),
        .wr_data (slot_wdata),
        .rd_data (slot_rdata)
    );

    // channel outputs
    assign req.ready        = (state_reg == S_IDLE);
    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.found_index  = out_found_reg;
    assign rsp.removed_slot = out_removed_reg;
    assign cfg.ready        = 1'b1;

endmodule

// ===== src/ptmr_checker.sv =====
// ptmr_checker: port-level checks on the refill block, attached to the top level by bind
// depends on ptmr_pkg for status codes
module ptmr_checker
    import ptmr_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic [1:0] status,
    input logic [7:0] found_index,
    input logic [5:0] removed_slot
);

    // a stalled response beat holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(status)
            && $stable(found_index) && $stable(removed_slot))
        else $error("response beat dropped or changed while stalled");

    // one item in work: ready drops right after a request beat
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while an item is in work");

    // deferred and no-descriptor results carry no indexes
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == STATUS_DEFER || status == STATUS_NO_DESC)
            |-> found_index == 8'd0 && removed_slot == 6'd0)
        else $error("index reported with a deferred or failed miss");

    // a new response appears only from a busy sequencer
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(!req_ready))
        else $error("response appeared while the sequencer idled");

endmodule

bind protection_table_miss_refill ptmr_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .status       (rsp.status),
    .found_index  (rsp.found_index),
    .removed_slot (rsp.removed_slot)
);
